### rtl/mmpr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the masked median pixel repair block.
// Used by mmpr_select and masked_median_pixel_repair; no dependencies.
package mmpr_pkg;

	localparam int DATA_W     = 16;
	localparam int CLASS_W    = 8;
	localparam int ENTRY_W    = DATA_W + CLASS_W;
	localparam int RES_W      = DATA_W + 1;
	localparam int IN_TDATA_W = 24;
	localparam int OUT_TDATA_W = 24;

	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 13;
	localparam int WIN_CFG_W  = 4;
	localparam int WID_CFG_W  = 12;
	localparam int HGT_CFG_W  = 13;

	localparam logic [CFG_ADDR_W-1:0] REG_WINDOW = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_WIDTH  = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT = 2'd2;

	localparam logic [WIN_CFG_W-1:0] WINDOW_RESET = 4'd3;
	localparam logic [WID_CFG_W-1:0] WIDTH_RESET  = 12'd2048;
	localparam logic [HGT_CFG_W-1:0] HEIGHT_RESET = 13'd4096;
	localparam int WINDOW_MIN = 3;

	localparam logic [CLASS_W-1:0] CLASS_GOOD   = 8'd0;
	localparam logic [CLASS_W-1:0] CLASS_REPAIR = 8'd1;

	localparam int DEF_MAX_WIDTH  = 2048;
	localparam int DEF_MAX_HEIGHT = 4096;
	localparam int DEF_MAX_WINDOW = 15;

	typedef struct packed {
		logic clear;
		logic push;
		logic start;
	} sel_ctl_t;

	typedef struct packed {
		logic             done;
		logic             empty;
		logic [RES_W-1:0] result;
	} sel_sts_t;

endpackage

### rtl/mmpr_select.sv
`timescale 1ns / 1ps
// Neighbour list memory and bitwise radix median selection.
// Depends on mmpr_pkg.
module mmpr_select #(
	parameter int MAX_WINDOW = mmpr_pkg::DEF_MAX_WINDOW
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mmpr_pkg::sel_ctl_t          ctl,
	input  logic [mmpr_pkg::DATA_W-1:0] push_data,
	output mmpr_pkg::sel_sts_t          sts
);
	import mmpr_pkg::*;

	localparam int NBR = MAX_WINDOW * MAX_WINDOW;
	localparam int AW  = $clog2(NBR);
	localparam int NW  = $clog2(NBR + 1);

	typedef enum logic [3:0] {
		SL_IDLE   = 4'b0001,
		SL_SCAN   = 4'b0010,
		SL_DECIDE = 4'b0100,
		SL_DONE   = 4'b1000
	} sl_state_t;

	sl_state_t         state_q;
	logic [DATA_W-1:0] nbr_mem [NBR];
	logic [DATA_W-1:0] rd_q;
	logic [NW-1:0]     n_q, k_q, cnt_q, idx_q;
	logic              vld_s1, second_q;
	logic [DATA_W-1:0] mask_q, bit_q, prefix_q, v0_q;
	logic [RES_W-1:0]  res_q;
	logic              rd_en, hit, ge;
	logic [DATA_W-1:0] pick;

	assign rd_en = (state_q == SL_SCAN) && (idx_q < n_q);
	assign hit   = vld_s1 && (((rd_q ^ prefix_q) & mask_q) == '0) && ((rd_q & bit_q) == '0);
	assign ge    = k_q >= cnt_q;
	assign pick  = ge ? (prefix_q | bit_q) : prefix_q;

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			nbr_mem[n_q[AW-1:0]] <= push_data;
		end
		if (rd_en) begin
			rd_q <= nbr_mem[idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= SL_IDLE;
			n_q      <= '0;
			k_q      <= '0;
			cnt_q    <= '0;
			idx_q    <= '0;
			vld_s1   <= 1'b0;
			second_q <= 1'b0;
			mask_q   <= '0;
			bit_q    <= '0;
			prefix_q <= '0;
			v0_q     <= '0;
			res_q    <= '0;
		end else begin
			if (ctl.clear) begin
				n_q <= '0;
			end else if (ctl.push) begin
				n_q <= n_q + 1'b1;
			end
			unique case (state_q)
				SL_IDLE: begin
					if (ctl.start) begin
						// lower middle rank first
						k_q      <= (n_q - 1'b1) >> 1;
						second_q <= 1'b0;
						prefix_q <= '0;
						mask_q   <= '0;
						bit_q    <= {1'b1, {(DATA_W-1){1'b0}}};
						cnt_q    <= '0;
						idx_q    <= '0;
						state_q  <= SL_SCAN;
					end
				end
				SL_SCAN: begin
					if (rd_en) begin
						idx_q <= idx_q + 1'b1;
					end
					vld_s1 <= rd_en;
					if (hit) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (!rd_en && !vld_s1) begin
						state_q <= SL_DECIDE;
					end
				end
				SL_DECIDE: begin
					if (ge) begin
						k_q <= k_q - cnt_q;
					end
					prefix_q <= pick;
					cnt_q    <= '0;
					idx_q    <= '0;
					if (bit_q[0]) begin
						if (!second_q) begin
							v0_q <= pick;
							if (n_q[0]) begin
								res_q   <= {pick, 1'b0};
								state_q <= SL_DONE;
							end else begin
								// upper middle rank for an even count
								second_q <= 1'b1;
								k_q      <= n_q >> 1;
								prefix_q <= '0;
								mask_q   <= '0;
								bit_q    <= {1'b1, {(DATA_W-1){1'b0}}};
								state_q  <= SL_SCAN;
							end
						end else begin
							res_q   <= {1'b0, v0_q} + {1'b0, pick};
							state_q <= SL_DONE;
						end
					end else begin
						mask_q  <= {1'b1, mask_q[DATA_W-1:1]};
						bit_q   <= bit_q >> 1;
						state_q <= SL_SCAN;
					end
				end
				SL_DONE: begin
					state_q <= SL_IDLE;
				end
				default: begin
					state_q <= SL_IDLE;
				end
			endcase
		end
	end

	assign sts.done   = (state_q == SL_DONE);
	assign sts.empty  = (n_q == '0);
	assign sts.result = res_q;

endmodule

### rtl/masked_median_pixel_repair.sv
`timescale 1ns / 1ps
// Masked median bad-pixel repair, top level. Depends on mmpr_pkg and mmpr_select.
// Pixels are held in a line store of MAX_WINDOW+1 rows by MAX_WIDTH entries.
//
// Items are taken one at a time. A repaired pixel runs one selection over its good
// neighbours, or two when the good count is even; each selection makes sixteen
// passes over the neighbour list memory, one read a cycle. No clearing pass
// follows reset. A new item is taken while a finished result waits on the output.
module masked_median_pixel_repair #(
	parameter int MAX_WIDTH  = mmpr_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = mmpr_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_WINDOW = mmpr_pkg::DEF_MAX_WINDOW
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [mmpr_pkg::IN_TDATA_W-1:0]  s_tdata,  // pixel_value[15:0], mask_class[23:16]
	input  logic                             s_tuser,  // mode
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [mmpr_pkg::OUT_TDATA_W-1:0] m_tdata,  // pixel_out_x2[16:0], zeros above
	output logic                             m_tuser,  // repaired
	output logic                             m_tlast,  // frame_last
	input  logic                             cfg_we,
	input  logic [mmpr_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [mmpr_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import mmpr_pkg::*;

	localparam int ROWS = MAX_WINDOW + 1;
	localparam int SW   = $clog2(ROWS);
	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int RW   = $clog2(MAX_HEIGHT);
	localparam int WX   = 14;
	localparam int HX   = 17;
	localparam int HB   = 4;
	localparam int LW   = RW + WX + 1;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_MUL  = 7'b0000010,
		ST_CMP  = 7'b0000100,
		ST_CTR  = 7'b0001000,
		ST_GATH = 7'b0010000,
		ST_SEL  = 7'b0100000,
		ST_FIN  = 7'b1000000
	} state_t;

	state_t               state_q;
	logic [WIN_CFG_W-1:0] win_q;
	logic [WID_CFG_W-1:0] wid_q;
	logic [HGT_CFG_W-1:0] hgt_q;

	logic [ENTRY_W-1:0] store_mem [ROWS][MAX_WIDTH];
	logic [ENTRY_W-1:0] rd_q;
	logic               rd_en;
	logic [SW-1:0]      rd_slot;
	logic [CW-1:0]      rd_col;

	logic [RW-1:0] in_row_q, out_row_q;
	logic [CW-1:0] in_col_q, out_col_q;
	logic [SW-1:0] in_slot_q, out_slot_q;
	logic          drain_q;

	logic [LW-1:0] need_p_q, lin_p_q;

	logic [RW-1:0]     gy_q, ye_q;
	logic [CW-1:0]     gx_q, xs_q, xe_q;
	logic [SW-1:0]     gslot_q;
	logic              gdone_q, gvld_s1;
	logic [RES_W-1:0]  res_q;
	logic              rep_q;

	logic              mvalid_q;
	logic [RES_W-1:0]  mres_q;
	logic              mrep_q, mlast_q;

	sel_ctl_t sel_ctl;
	sel_sts_t sel_sts;

	// effective frame size and window half
	logic [WX-1:0]  eff_w;
	logic [HX-1:0]  eff_h_x;
	logic [RW:0]    eff_h;
	logic [HB-1:0]  win_c, half;
	logic [RW:0]    nr_x, ye_x;
	logic [RW-1:0]  nr;
	logic [CW:0]    nc_x;
	logic [CW-1:0]  nc;
	logic [RW-1:0]  ys;
	logic [HB-1:0]  dy;
	logic [CW-1:0]  xs;
	logic [SW:0]    slot_start_x;
	logic [LW-1:0]  need_lin, in_lin;
	logic           in_pix, in_col_end, in_row_end, out_col_end, out_row_end;
	logic           accept;

	always_comb begin
		if (wid_q == '0) begin
			eff_w = WX'(1);
		end else if (WX'(wid_q) > WX'(MAX_WIDTH)) begin
			eff_w = WX'(MAX_WIDTH);
		end else begin
			eff_w = WX'(wid_q);
		end
		if (hgt_q == '0) begin
			eff_h_x = HX'(1);
		end else if (HX'(hgt_q) > HX'(MAX_HEIGHT)) begin
			eff_h_x = HX'(MAX_HEIGHT);
		end else begin
			eff_h_x = HX'(hgt_q);
		end
		eff_h = eff_h_x[RW:0];
		if (win_q < HB'(WINDOW_MIN)) begin
			win_c = HB'(WINDOW_MIN);
		end else if (win_q > HB'(MAX_WINDOW)) begin
			win_c = HB'(MAX_WINDOW);
		end else begin
			win_c = win_q;
		end
		half = (win_c - 1'b1) >> 1;
	end

	assign in_col_end  = (WX'(in_col_q) + WX'(1)) >= eff_w;
	assign in_row_end  = ({1'b0, in_row_q} + 1'b1) >= eff_h;
	assign out_col_end = (WX'(out_col_q) + WX'(1)) >= eff_w;
	assign out_row_end = ({1'b0, out_row_q} + 1'b1) >= eff_h;

	always_comb begin
		nr_x = {1'b0, out_row_q} + (RW+1)'(half);
		if (nr_x > eff_h - 1'b1) begin
			nr_x = eff_h - 1'b1;
		end
		nr = nr_x[RW-1:0];
		nc_x = {1'b0, out_col_q} + (CW+1)'(half);
		if (WX'(nc_x) > eff_w - 1'b1) begin
			nc_x = (CW+1)'(eff_w - 1'b1);
		end
		nc = nc_x[CW-1:0];
		ye_x = nr_x;
		ys = (out_row_q >= RW'(half)) ? out_row_q - RW'(half) : '0;
		dy = HB'(out_row_q - ys);
		xs = (out_col_q >= CW'(half)) ? out_col_q - CW'(half) : '0;
		if ((SW+1)'(out_slot_q) >= (SW+1)'(dy)) begin
			slot_start_x = (SW+1)'(out_slot_q) - (SW+1)'(dy);
		end else begin
			slot_start_x = (SW+1)'(out_slot_q) + (SW+1)'(ROWS) - (SW+1)'(dy);
		end
	end

	assign need_lin = need_p_q + LW'(nc);
	assign in_lin   = lin_p_q + LW'(in_col_q);
	assign in_pix   = !s_tuser && !drain_q;
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// store port: read mux
	always_comb begin
		rd_en   = 1'b0;
		rd_slot = out_slot_q;
		rd_col  = out_col_q;
		if (state_q == ST_CMP) begin
			rd_en = drain_q || (need_lin < in_lin);
		end else if (state_q == ST_GATH) begin
			rd_en   = !gdone_q;
			rd_slot = gslot_q;
			rd_col  = gx_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in_pix) begin
			store_mem[in_slot_q][in_col_q] <= s_tdata[ENTRY_W-1:0];
		end
		if (rd_en) begin
			rd_q <= store_mem[rd_slot][rd_col];
		end
	end

	always_comb begin
		sel_ctl.clear = (state_q == ST_CTR);
		sel_ctl.push  = (state_q == ST_GATH) && gvld_s1 && (rd_q[ENTRY_W-1:DATA_W] == CLASS_GOOD);
		sel_ctl.start = (state_q == ST_GATH) && gdone_q && !gvld_s1 && !sel_sts.empty;
	end

	mmpr_select #(
		.MAX_WINDOW(MAX_WINDOW)
	) u_select (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (sel_ctl),
		.push_data(rd_q[DATA_W-1:0]),
		.sts      (sel_sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= WINDOW_RESET;
			wid_q <= WIDTH_RESET;
			hgt_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_WINDOW: win_q <= cfg_data[WIN_CFG_W-1:0];
				REG_WIDTH:  wid_q <= cfg_data[WID_CFG_W-1:0];
				REG_HEIGHT: hgt_q <= cfg_data[HGT_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			in_row_q   <= '0;
			in_col_q   <= '0;
			in_slot_q  <= '0;
			out_row_q  <= '0;
			out_col_q  <= '0;
			out_slot_q <= '0;
			drain_q    <= 1'b0;
			need_p_q   <= '0;
			lin_p_q    <= '0;
			gy_q       <= '0;
			ye_q       <= '0;
			gx_q       <= '0;
			xs_q       <= '0;
			xe_q       <= '0;
			gslot_q    <= '0;
			gdone_q    <= 1'b0;
			gvld_s1    <= 1'b0;
			res_q      <= '0;
			rep_q      <= 1'b0;
			mvalid_q   <= 1'b0;
			mres_q     <= '0;
			mrep_q     <= 1'b0;
			mlast_q    <= 1'b0;
		end else begin
			if ((state_q == ST_FIN) && (!mvalid_q || m_tready)) begin
				mvalid_q <= 1'b1;
			end else if (mvalid_q && m_tready) begin
				mvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_pix) begin
							if (in_col_end) begin
								in_col_q <= '0;
								if (in_row_end) begin
									in_row_q  <= '0;
									in_slot_q <= '0;
									drain_q   <= 1'b1;
								end else begin
									in_row_q  <= in_row_q + 1'b1;
									in_slot_q <= (in_slot_q == SW'(ROWS-1)) ? '0 : in_slot_q + 1'b1;
								end
							end else begin
								in_col_q <= in_col_q + 1'b1;
							end
						end
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					need_p_q <= LW'(nr) * LW'(eff_w);
					lin_p_q  <= LW'(in_row_q) * LW'(eff_w);
					state_q  <= ST_CMP;
				end
				ST_CMP: begin
					state_q <= rd_en ? ST_CTR : ST_IDLE;
				end
				ST_CTR: begin
					res_q <= {rd_q[DATA_W-1:0], 1'b0};
					rep_q <= 1'b0;
					// a window left empty by a shrunk frame has no neighbours
					if ((rd_q[ENTRY_W-1:DATA_W] == CLASS_REPAIR) && (ys <= ye_x[RW-1:0]) &&
					    (xs <= nc)) begin
						gy_q    <= ys;
						ye_q    <= ye_x[RW-1:0];
						gx_q    <= xs;
						xs_q    <= xs;
						xe_q    <= nc;
						gslot_q <= slot_start_x[SW-1:0];
						gdone_q <= 1'b0;
						gvld_s1 <= 1'b0;
						state_q <= ST_GATH;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_GATH: begin
					gvld_s1 <= rd_en;
					if (rd_en) begin
						if (gx_q == xe_q) begin
							gx_q <= xs_q;
							if (gy_q == ye_q) begin
								gdone_q <= 1'b1;
							end else begin
								gy_q    <= gy_q + 1'b1;
								gslot_q <= (gslot_q == SW'(ROWS-1)) ? '0 : gslot_q + 1'b1;
							end
						end else begin
							gx_q <= gx_q + 1'b1;
						end
					end
					if (gdone_q && !gvld_s1) begin
						// no good neighbour: pass the value through
						state_q <= sel_sts.empty ? ST_FIN : ST_SEL;
					end
				end
				ST_SEL: begin
					if (sel_sts.done) begin
						res_q   <= sel_sts.result;
						rep_q   <= 1'b1;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!mvalid_q || m_tready) begin
						mres_q   <= res_q;
						mrep_q   <= rep_q;
						mlast_q  <= out_row_end && out_col_end;
						if (out_col_end) begin
							out_col_q <= '0;
							if (out_row_end) begin
								out_row_q  <= '0;
								out_slot_q <= '0;
								drain_q    <= 1'b0;
							end else begin
								out_row_q  <= out_row_q + 1'b1;
								out_slot_q <= (out_slot_q == SW'(ROWS-1)) ? '0 : out_slot_q + 1'b1;
							end
						end else begin
							out_col_q <= out_col_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = mvalid_q;
	assign m_tdata  = {{(OUT_TDATA_W-RES_W){1'b0}}, mres_q};
	assign m_tuser  = mrep_q;
	assign m_tlast  = mlast_q;

endmodule
